/* src/dsle_pkg.sv */
// ----------------------------------------------------------------------------
// dsle_pkg
// Shared types, character codes and helpers for the dot-stuffing line encoder.
// ----------------------------------------------------------------------------
package dsle_pkg;

  localparam logic [7:0]  CH_LF     = 8'h0A;
  localparam logic [7:0]  CH_CR     = 8'h0D;
  localparam logic [7:0]  CH_DOT    = 8'h2E;
  localparam logic [15:0] CRLF_PAIR = 16'h0D0A;

  localparam int unsigned FIFO_DEPTH = 2;

  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_PRE      = 3'd0;
  localparam logic [STEP_W-1:0] STEP_DATA     = 3'd1;
  localparam logic [STEP_W-1:0] STEP_END_CR   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_END_LF   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_END_DOT  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_END_TCR  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_END_LAST = 3'd4;

  localparam logic [1:0] OUT_CNT_FULL = 2'd2;

  typedef enum logic {
    FUNC_DATA = 1'b0,
    FUNC_END  = 1'b1
  } func_e;

  typedef struct packed {
    func_e      func;
    logic       pre_en;
    logic [7:0] pre_byte;
    logic [7:0] data;
  } dsle_cmd_t;

  function automatic logic [STEP_W-1:0] cmd_start_step(input dsle_cmd_t cmd);
    logic [STEP_W-1:0] s;
    if (cmd.func == FUNC_DATA) begin
      s = cmd.pre_en ? STEP_PRE : STEP_DATA;
    end else begin
      s = cmd.pre_en ? STEP_END_CR : STEP_END_DOT;
    end
    return s;
  endfunction

  function automatic logic [7:0] cmd_byte(input dsle_cmd_t cmd, input logic [STEP_W-1:0] step);
    logic [7:0] b;
    if (cmd.func == FUNC_DATA) begin
      b = (step == STEP_PRE) ? cmd.pre_byte : cmd.data;
    end else begin
      case (step)
        STEP_END_CR:  b = CH_CR;
        STEP_END_LF:  b = CH_LF;
        STEP_END_DOT: b = CH_DOT;
        STEP_END_TCR: b = CH_CR;
        default:      b = CH_LF;
      endcase
    end
    return b;
  endfunction

endpackage

/* src/dsle_front.sv */
// ----------------------------------------------------------------------------
// dsle_front
// Accepts message items, tracks line and output history, and issues one
// command per item describing the output run it causes.
// ----------------------------------------------------------------------------
module dsle_front
  import dsle_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  logic      func_i,
  input  logic [7:0] data_byte_i,
  output dsle_cmd_t cmd_o
);

  logic        at_line_start_q, at_line_start_d;
  logic [7:0]  prev_in_q, prev_in_d;
  logic        any_seen_q, any_seen_d;
  logic [15:0] last_two_q, last_two_d;
  logic [1:0]  out_cnt_q, out_cnt_d;

  always_comb begin
    cmd_o           = '0;
    at_line_start_d = at_line_start_q;
    prev_in_d       = prev_in_q;
    any_seen_d      = any_seen_q;
    last_two_d      = last_two_q;
    out_cnt_d       = out_cnt_q;
    if (func_i == FUNC_END) begin
      cmd_o.func      = FUNC_END;
      cmd_o.pre_en    = (out_cnt_q != OUT_CNT_FULL) || (last_two_q != CRLF_PAIR);
      cmd_o.pre_byte  = CH_CR;
      cmd_o.data      = CH_LF;
      at_line_start_d = 1'b1;
      prev_in_d       = '0;
      any_seen_d      = 1'b0;
      last_two_d      = '0;
      out_cnt_d       = '0;
    end else begin
      cmd_o.func = FUNC_DATA;
      cmd_o.data = data_byte_i;
      if (data_byte_i == CH_LF) begin
        cmd_o.pre_en    = any_seen_q && (prev_in_q != CH_CR);
        cmd_o.pre_byte  = CH_CR;
        at_line_start_d = 1'b1;
      end else if (data_byte_i == CH_DOT) begin
        cmd_o.pre_en    = at_line_start_q;
        cmd_o.pre_byte  = CH_DOT;
        at_line_start_d = 1'b0;
      end else begin
        at_line_start_d = 1'b0;
      end
      if (cmd_o.pre_en) begin
        last_two_d = {cmd_o.pre_byte, data_byte_i};
        out_cnt_d  = OUT_CNT_FULL;
      end else begin
        last_two_d = {last_two_q[7:0], data_byte_i};
        out_cnt_d  = (out_cnt_q == OUT_CNT_FULL) ? OUT_CNT_FULL : out_cnt_q + 2'd1;
      end
      prev_in_d  = data_byte_i;
      any_seen_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_line_start_q <= 1'b1;
      prev_in_q       <= '0;
      any_seen_q      <= 1'b0;
      last_two_q      <= '0;
      out_cnt_q       <= '0;
    end else if (accept_i) begin
      at_line_start_q <= at_line_start_d;
      prev_in_q       <= prev_in_d;
      any_seen_q      <= any_seen_d;
      last_two_q      <= last_two_d;
      out_cnt_q       <= out_cnt_d;
    end
  end

endmodule

/* src/dsle_fifo.sv */
// ----------------------------------------------------------------------------
// dsle_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module dsle_fifo
  import dsle_pkg::*;
#(
  parameter int unsigned Depth = FIFO_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  dsle_cmd_t wdata_i,
  input  logic      pop_i,
  output dsle_cmd_t rdata_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  dsle_cmd_t            mem_q [Depth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* src/dsle_back.sv */
// ----------------------------------------------------------------------------
// dsle_back
// Expands queued commands into output bytes, one per cycle while out_ready_i
// does not stall the output, through a registered output stage.
// ----------------------------------------------------------------------------
module dsle_back
  import dsle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dsle_cmd_t  cmd_i,
  input  logic       cmd_empty_i,
  output logic       cmd_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o,
  output logic       message_end_o
);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [STEP_W-1:0] cur_step;
  logic              load;
  logic              is_last;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q;
  logic              last_q;
  logic              msg_end_q;

  assign cur_step = busy_q ? step_q : cmd_start_step(cmd_i);
  assign load     = !cmd_empty_i && (!out_valid_q || out_ready_i);
  assign is_last  = (cmd_i.func == FUNC_DATA) ? (cur_step == STEP_DATA)
                                              : (cur_step == STEP_END_LAST);
  assign cmd_pop_o = load && is_last;

  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      busy_d      = !is_last;
      step_d      = cur_step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= cmd_byte(cmd_i, cur_step);
      last_q     <= is_last;
      msg_end_q  <= is_last && (cmd_i.func == FUNC_END);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = last_q;
  assign message_end_o = msg_end_q;

endmodule

/* src/dot_stuffing_line_encoder.sv */
// ----------------------------------------------------------------------------
// dot_stuffing_line_encoder
// Dot-stuffing line encoder with CR LF normalization and message terminator.
// ----------------------------------------------------------------------------
// Each input item is one message byte or an end-of-message mark; each output
// item is one escaped byte. A data byte yields one or two output bytes (an
// inserted CR before LF, or a doubled leading period), an end mark yields three
// or five (optional CR LF, then '.', CR, LF with message_end set). The output
// port moves one byte per cycle while out_ready_i is high. Inputs are accepted
// back to back while the command queue (Depth entries) has room; the byte
// sequencer behind it and its output register set the throughput.
// ----------------------------------------------------------------------------
module dot_stuffing_line_encoder
  import dsle_pkg::*;
#(
  parameter int unsigned Depth = FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       func_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o,
  output logic       message_end_o
);

  dsle_cmd_t cmd_wr;
  dsle_cmd_t cmd_rd;
  logic      fifo_full;
  logic      fifo_empty;
  logic      fifo_pop;
  logic      accept;

  assign in_ready_o = !fifo_full;
  assign accept     = in_valid_i && in_ready_o;

  dsle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .func_i      (func_i),
    .data_byte_i (data_byte_i),
    .cmd_o       (cmd_wr)
  );

  dsle_fifo #(
    .Depth (Depth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .wdata_i (cmd_wr),
    .pop_i   (fifo_pop),
    .rdata_o (cmd_rd),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  dsle_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_rd),
    .cmd_empty_i   (fifo_empty),
    .cmd_pop_o     (fifo_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .message_end_o (message_end_o)
  );

endmodule

/* src/dsle_checker.sv */
// ----------------------------------------------------------------------------
// dsle_checker
// Port-level checks for the dot-stuffing line encoder.
// ----------------------------------------------------------------------------
module dsle_checker
  import dsle_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       last_of_run_o,
  input logic       message_end_o
);

  logic [7:0] prev_out_q;
  logic       out_fire;

  assign out_fire = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_out_q <= '0;
    end else if (out_fire) begin
      prev_out_q <= out_byte_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(last_of_run_o) && $stable(message_end_o))
    else $error("output item changed while stalled");

  a_end_is_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_end_o |-> out_byte_o == CH_LF && last_of_run_o)
    else $error("message end not on final LF");

  a_end_after_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && message_end_o |-> prev_out_q == CH_CR)
    else $error("terminator LF not preceded by CR");

  a_dot_before_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && message_end_o |-> $past(prev_out_q) == CH_DOT || !$past(out_fire))
    else $error("terminator line does not start with a period");

  a_stall_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |-> out_valid_o)
    else $error("input stalled with no output item pending");

endmodule

bind dot_stuffing_line_encoder dsle_checker u_dsle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .out_byte_o    (out_byte_o),
  .last_of_run_o (last_of_run_o),
  .message_end_o (message_end_o)
);
